/* sv/cge_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cge_pkg
// Shared types and codes of the Cauchy entry modulo p block.
// ----------------------------------------------------------------------------
package cge_pkg;

   localparam int IDX_W   = 12;
   localparam int DIM_W   = 13;
   localparam int CSR_W   = 63;
   localparam int CSR_A_W = 3;
   localparam int STAT_W  = 2;
   localparam int DVD_W   = 64;

   localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
   localparam logic [STAT_W-1:0] ST_RANGE = 2'd1;
   localparam logic [STAT_W-1:0] ST_NOINV = 2'd2;

   localparam logic [CSR_A_W-1:0] REG_MODULUS   = 3'd0;
   localparam logic [CSR_A_W-1:0] REG_ROW_POINT = 3'd1;
   localparam logic [CSR_A_W-1:0] REG_COL_POINT = 3'd2;
   localparam logic [CSR_A_W-1:0] REG_RATIO     = 3'd3;
   localparam logic [CSR_A_W-1:0] REG_NUM_ROWS  = 3'd4;
   localparam logic [CSR_A_W-1:0] REG_NUM_COLS  = 3'd5;

   localparam int QDEPTH = 2;
   localparam int QPTR_W = 1;
   localparam int QCNT_W = 2;

   typedef struct packed {
      logic [IDX_W-1:0]  row_index;
      logic [IDX_W-1:0]  col_index;
      logic [STAT_W-1:0] status;
   } job_type;

endpackage

/* sv/cge_ifc.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cge_req_if / cge_rsp_if
// Valid/ready channels for requests and results.
// ----------------------------------------------------------------------------
interface cge_req_if;
   logic        valid;
   logic        ready;
   logic [11:0] row_index;
   logic [11:0] col_index;
   modport source (output valid, output row_index, output col_index, input ready);
   modport sink (input valid, input row_index, input col_index, output ready);
endinterface

interface cge_rsp_if;
   logic        valid;
   logic        ready;
   logic [62:0] entry_value;
   logic [1:0]  status;
   modport source (output valid, output entry_value, output status, input ready);
   modport sink (input valid, input entry_value, input status, output ready);
endinterface

/* sv/cge_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cge_front
// Accepts requests, checks the indexes and the modulus, and queues them.
// ----------------------------------------------------------------------------
module cge_front #(
   parameter int W       = 63,
   parameter int MAX_DIM = 4096
) (
   input  logic                      clock,
   input  logic                      reset,
   cge_req_if.sink                   req_ch,
   input  logic [W-1:0]              modulus,
   input  logic [cge_pkg::DIM_W-1:0] num_rows,
   input  logic [cge_pkg::DIM_W-1:0] num_cols,
   output cge_pkg::job_type          q_item,
   output logic                      q_valid,
   input  logic                      q_pop
);
   import cge_pkg::*;

   job_type           q_ff [QDEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0] cnt_ff, cnt_in;
   logic              push;
   logic              out_rng;
   job_type           job;

   assign req_ch.ready = (cnt_ff != QCNT_W'(QDEPTH));
   assign push = req_ch.valid && req_ch.ready;

   always_comb begin
      out_rng = (32'(req_ch.row_index) >= 32'(num_rows)) ||
                (32'(req_ch.row_index) >= MAX_DIM) ||
                (32'(req_ch.col_index) >= 32'(num_cols)) ||
                (32'(req_ch.col_index) >= MAX_DIM);
      job.row_index = req_ch.row_index;
      job.col_index = req_ch.col_index;
      priority if (out_rng) begin
         job.status = ST_RANGE;
      end else if (modulus < W'(2)) begin
         job.status = ST_NOINV;
      end else begin
         job.status = ST_OK;
      end
   end

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = q_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      cnt_in    = cnt_ff + QCNT_W'(push) - QCNT_W'(q_pop);
   end

   assign q_valid = (cnt_ff != '0);
   assign q_item  = q_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wr_ptr_ff] <= job;
      end
   end

endmodule

/* sv/cge_div.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cge_div
// Restoring divider, one quotient bit per cycle, 64-bit dividend.
// ----------------------------------------------------------------------------
module cge_div #(
   parameter int W = 63
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   input  logic [cge_pkg::DVD_W-1:0] dividend,
   input  logic [W-1:0]              divisor,
   output logic                      done,
   output logic [W-1:0]              quotient,
   output logic [W-1:0]              remainder
);
   import cge_pkg::*;

   localparam int CNT_W = $clog2(DVD_W + 1);

   logic [W-1:0]     rem_ff, rem_in;
   logic [DVD_W-1:0] quo_ff, quo_in;
   logic [W-1:0]     dsr_ff, dsr_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             done_ff, done_in;
   logic [W:0]       trial;
   logic             ge;

   always_comb begin
      trial  = {rem_ff, quo_ff[DVD_W-1]};
      ge     = (trial >= {1'b0, dsr_ff});
      rem_in = rem_ff;
      quo_in = quo_ff;
      dsr_in = dsr_ff;
      cnt_in = cnt_ff;
      done_in = 1'b0;
      if (start) begin
         rem_in = '0;
         quo_in = dividend;
         dsr_in = divisor;
         cnt_in = CNT_W'(DVD_W);
      end else if (cnt_ff != '0) begin
         rem_in  = ge ? W'(trial - {1'b0, dsr_ff}) : trial[W-1:0];
         quo_in  = {quo_ff[DVD_W-2:0], ge};
         cnt_in  = cnt_ff - 1'b1;
         done_in = (cnt_ff == CNT_W'(1));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dsr_ff <= dsr_in;
   end

   assign done      = done_ff;
   assign quotient  = quo_ff[W-1:0];
   assign remainder = rem_ff;

endmodule

/* sv/cge_mulmod.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cge_mulmod
// Shared modular multiplier, shift-and-add, one multiplier bit per cycle.
// ----------------------------------------------------------------------------
module cge_mulmod #(
   parameter int W = 63
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   input  logic [W-1:0] op_a,
   input  logic [W-1:0] op_b,
   input  logic [W-1:0] modulus,
   output logic         done,
   output logic [W-1:0] product
);
   localparam int CNT_W = $clog2(W + 1);

   logic [W-1:0]     a_ff, a_in;
   logic [W-1:0]     b_ff, b_in;
   logic [W-1:0]     p_ff, p_in;
   logic [W-1:0]     acc_ff, acc_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             done_ff, done_in;
   logic [W:0]       dbl, dbl_r, sum;

   always_comb begin
      dbl   = {acc_ff, 1'b0};
      dbl_r = (dbl >= {1'b0, p_ff}) ? dbl - {1'b0, p_ff} : dbl;
      sum   = dbl_r + (b_ff[W-1] ? {1'b0, a_ff} : '0);
      a_in  = a_ff;
      b_in  = b_ff;
      p_in  = p_ff;
      acc_in = acc_ff;
      cnt_in = cnt_ff;
      done_in = 1'b0;
      if (start) begin
         a_in   = op_a;
         b_in   = op_b;
         p_in   = modulus;
         acc_in = '0;
         cnt_in = CNT_W'(W);
      end else if (cnt_ff != '0) begin
         acc_in  = (sum >= {1'b0, p_ff}) ? W'(sum - {1'b0, p_ff}) : sum[W-1:0];
         b_in    = {b_ff[W-2:0], 1'b0};
         cnt_in  = cnt_ff - 1'b1;
         done_in = (cnt_ff == CNT_W'(1));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      a_ff   <= a_in;
      b_ff   <= b_in;
      p_ff   <= p_in;
      acc_ff <= acc_in;
   end

   assign done    = done_ff;
   assign product = acc_ff;

endmodule

/* sv/cge_back.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cge_back
// Sequencer: reduces the points, forms both powers and inverts the difference.
// ----------------------------------------------------------------------------
module cge_back #(
   parameter int W = 63
) (
   input  logic                      clock,
   input  logic                      reset,
   input  cge_pkg::job_type          q_item,
   input  logic                      q_valid,
   output logic                      q_pop,
   input  logic [W-1:0]              modulus,
   input  logic [cge_pkg::CSR_W-1:0] row_point,
   input  logic [cge_pkg::CSR_W-1:0] col_point,
   input  logic [cge_pkg::CSR_W-1:0] ratio,
   cge_rsp_if.source                 rsp_ch
);
   import cge_pkg::*;

   localparam logic [3:0] S_IDLE  = 4'd0;
   localparam logic [3:0] S_RED_U = 4'd1;
   localparam logic [3:0] S_RED_V = 4'd2;
   localparam logic [3:0] S_RED_R = 4'd3;
   localparam logic [3:0] S_POW   = 4'd4;
   localparam logic [3:0] S_PMR   = 4'd5;
   localparam logic [3:0] S_PMB   = 4'd6;
   localparam logic [3:0] S_MULPT = 4'd7;
   localparam logic [3:0] S_EUC   = 4'd8;
   localparam logic [3:0] S_EDIV  = 4'd9;
   localparam logic [3:0] S_EMUL  = 4'd10;
   localparam logic [3:0] S_OUT   = 4'd11;

   function automatic logic [W-1:0] sub_mod(input logic [W-1:0] a, input logic [W-1:0] b,
                                            input logic [W-1:0] p);
      sub_mod = (a >= b) ? a - b : a + (p - b);
   endfunction

   logic [3:0]       state_ff, state_in;
   logic             pass_ff, pass_in;
   logic [IDX_W-1:0] row_ff, row_in, col_ff, col_in, e_ff, e_in;
   logic [W-1:0]     u_ff, u_in, v_ff, v_in, rho_ff, rho_in, base_ff, base_in;
   logic [W-1:0]     r_ff, r_in, a_ff, a_in;
   logic [W-1:0]     r0_ff, r0_in, r1_ff, r1_in, t0_ff, t0_in, t1_ff, t1_in;
   logic [W-1:0]     nr_ff, nr_in;
   logic [DVD_W-1:0] div_x_ff, div_x_in;
   logic [W-1:0]     div_y_ff, div_y_in;
   logic             div_go_ff, div_go_in;
   logic [W-1:0]     mul_a_ff, mul_a_in, mul_b_ff, mul_b_in;
   logic             mul_go_ff, mul_go_in;
   logic [CSR_W-1:0]  val_ff, val_in;
   logic [STAT_W-1:0] st_ff, st_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [CSR_W-1:0]  rsp_value_ff, rsp_value_in;
   logic [STAT_W-1:0] rsp_status_ff, rsp_status_in;

   logic             div_done, mul_done;
   logic [W-1:0]     div_quo, div_rem, mul_res, qm;
   logic [DVD_W-1:0] t0_wide;

   cge_div #(.W(W)) u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (div_go_ff),
      .dividend  (div_x_ff),
      .divisor   (div_y_ff),
      .done      (div_done),
      .quotient  (div_quo),
      .remainder (div_rem)
   );

   cge_mulmod #(.W(W)) u_mul (
      .clock   (clock),
      .reset   (reset),
      .start   (mul_go_ff),
      .op_a    (mul_a_ff),
      .op_b    (mul_b_ff),
      .modulus (modulus),
      .done    (mul_done),
      .product (mul_res)
   );

   always_comb begin
      qm      = (div_quo >= modulus) ? div_quo - modulus : div_quo;
      t0_wide = DVD_W'(t0_ff);
      state_in = state_ff;
      pass_in = pass_ff;
      row_in = row_ff;
      col_in = col_ff;
      e_in = e_ff;
      u_in = u_ff;
      v_in = v_ff;
      rho_in = rho_ff;
      base_in = base_ff;
      r_in = r_ff;
      a_in = a_ff;
      r0_in = r0_ff;
      r1_in = r1_ff;
      t0_in = t0_ff;
      t1_in = t1_ff;
      nr_in = nr_ff;
      div_x_in = div_x_ff;
      div_y_in = div_y_ff;
      div_go_in = 1'b0;
      mul_a_in = mul_a_ff;
      mul_b_in = mul_b_ff;
      mul_go_in = 1'b0;
      val_in = val_ff;
      st_in = st_ff;
      q_pop = 1'b0;
      rsp_valid_in = rsp_valid_ff && !rsp_ch.ready;
      rsp_value_in = rsp_value_ff;
      rsp_status_in = rsp_status_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (q_valid) begin
               q_pop  = 1'b1;
               row_in = q_item.row_index;
               col_in = q_item.col_index;
               if (q_item.status != ST_OK) begin
                  st_in    = q_item.status;
                  val_in   = '0;
                  state_in = S_OUT;
               end else begin
                  div_x_in  = DVD_W'(row_point);
                  div_y_in  = modulus;
                  div_go_in = 1'b1;
                  state_in  = S_RED_U;
               end
            end
         end
         S_RED_U: begin
            if (div_done) begin
               u_in      = div_rem;
               div_x_in  = DVD_W'(col_point);
               div_go_in = 1'b1;
               state_in  = S_RED_V;
            end
         end
         S_RED_V: begin
            if (div_done) begin
               v_in      = div_rem;
               div_x_in  = DVD_W'(ratio);
               div_go_in = 1'b1;
               state_in  = S_RED_R;
            end
         end
         S_RED_R: begin
            if (div_done) begin
               rho_in   = div_rem;
               base_in  = div_rem;
               e_in     = row_ff;
               r_in     = W'(1);
               pass_in  = 1'b0;
               state_in = S_POW;
            end
         end
         S_POW: begin
            mul_go_in = 1'b1;
            if (e_ff == '0) begin
               mul_a_in = pass_ff ? v_ff : u_ff;
               mul_b_in = r_ff;
               state_in = S_MULPT;
            end else if (e_ff[0]) begin
               mul_a_in = r_ff;
               mul_b_in = base_ff;
               state_in = S_PMR;
            end else begin
               mul_a_in = base_ff;
               mul_b_in = base_ff;
               state_in = S_PMB;
            end
         end
         S_PMR: begin
            if (mul_done) begin
               r_in      = mul_res;
               mul_a_in  = base_ff;
               mul_b_in  = base_ff;
               mul_go_in = 1'b1;
               state_in  = S_PMB;
            end
         end
         S_PMB: begin
            if (mul_done) begin
               base_in  = mul_res;
               e_in     = e_ff >> 1;
               state_in = S_POW;
            end
         end
         S_MULPT: begin
            if (mul_done) begin
               if (!pass_ff) begin
                  // Row term done: start the column power.
                  a_in     = mul_res;
                  pass_in  = 1'b1;
                  base_in  = rho_ff;
                  e_in     = col_ff;
                  r_in     = W'(1);
                  state_in = S_POW;
               end else begin
                  r0_in    = modulus;
                  r1_in    = sub_mod(a_ff, mul_res, modulus);
                  t0_in    = '0;
                  t1_in    = W'(1);
                  state_in = S_EUC;
               end
            end
         end
         S_EUC: begin
            if (r1_ff == '0) begin
               if (r0_ff == W'(1)) begin
                  st_in  = ST_OK;
                  val_in = t0_wide[CSR_W-1:0];
               end else begin
                  st_in  = ST_NOINV;
                  val_in = '0;
               end
               state_in = S_OUT;
            end else begin
               div_x_in  = DVD_W'(r0_ff);
               div_y_in  = r1_ff;
               div_go_in = 1'b1;
               state_in  = S_EDIV;
            end
         end
         S_EDIV: begin
            if (div_done) begin
               nr_in     = div_rem;
               mul_a_in  = qm;
               mul_b_in  = t1_ff;
               mul_go_in = 1'b1;
               state_in  = S_EMUL;
            end
         end
         S_EMUL: begin
            if (mul_done) begin
               r0_in    = r1_ff;
               r1_in    = nr_ff;
               t0_in    = t1_ff;
               t1_in    = sub_mod(t0_ff, mul_res, modulus);
               state_in = S_EUC;
            end
         end
         S_OUT: begin
            // Hold until the output register frees up.
            if (!rsp_valid_ff || rsp_ch.ready) begin
               rsp_valid_in  = 1'b1;
               rsp_value_in  = val_ff;
               rsp_status_in = st_ff;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         div_go_ff    <= 1'b0;
         mul_go_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         div_go_ff    <= div_go_in;
         mul_go_ff    <= mul_go_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pass_ff <= pass_in;
      row_ff <= row_in;
      col_ff <= col_in;
      e_ff <= e_in;
      u_ff <= u_in;
      v_ff <= v_in;
      rho_ff <= rho_in;
      base_ff <= base_in;
      r_ff <= r_in;
      a_ff <= a_in;
      r0_ff <= r0_in;
      r1_ff <= r1_in;
      t0_ff <= t0_in;
      t1_ff <= t1_in;
      nr_ff <= nr_in;
      div_x_ff <= div_x_in;
      div_y_ff <= div_y_in;
      mul_a_ff <= mul_a_in;
      mul_b_ff <= mul_b_in;
      val_ff <= val_in;
      st_ff <= st_in;
      rsp_value_ff <= rsp_value_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign rsp_ch.valid       = rsp_valid_ff;
   assign rsp_ch.entry_value = rsp_value_ff;
   assign rsp_ch.status      = rsp_status_ff;

endmodule

/* sv/cauchy_geometric_entry_mod_p_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cauchy_geometric_entry_mod_p_core
// One entry 1 / (u1*rho^i - v1*rho^j) mod p of a geometric Cauchy matrix.
// ----------------------------------------------------------------------------
// Requests are checked and queued (two deep) by the front end; one sequencer
// then works one request at a time on a bit-serial divider and a bit-serial
// modular multiplier. An in-range request costs three reductions, two
// multiplies per set bit and one per clear bit of i and of j, two point
// multiplies, and per extended Euclid step one division and one multiply.
// Out-of-range requests and a modulus below two skip the arithmetic.
// The result sits in an output register, so a new request can be queued
// while a result waits.
module cauchy_geometric_entry_mod_p_core #(
   parameter int MOD_BITS = 63,
   parameter int MAX_DIM  = 4096
) (
   input  logic                        clock,
   input  logic                        reset,
   cge_req_if.sink                     req_ch,
   cge_rsp_if.source                   rsp_ch,
   input  logic                        csr_we,
   input  logic [cge_pkg::CSR_A_W-1:0] csr_index,
   input  logic [cge_pkg::CSR_W-1:0]   csr_wdata
);
   import cge_pkg::*;

   logic [MOD_BITS-1:0] modulus_ff, modulus_in;
   logic [CSR_W-1:0]    row_point_ff, row_point_in;
   logic [CSR_W-1:0]    col_point_ff, col_point_in;
   logic [CSR_W-1:0]    ratio_ff, ratio_in;
   logic [DIM_W-1:0]    num_rows_ff, num_rows_in;
   logic [DIM_W-1:0]    num_cols_ff, num_cols_in;
   logic [DVD_W-1:0]    wdata_wide;
   job_type             q_item;
   logic                q_valid, q_pop;

   always_comb begin
      wdata_wide   = DVD_W'(csr_wdata);
      modulus_in   = modulus_ff;
      row_point_in = row_point_ff;
      col_point_in = col_point_ff;
      ratio_in     = ratio_ff;
      num_rows_in  = num_rows_ff;
      num_cols_in  = num_cols_ff;
      if (csr_we) begin
         unique case (csr_index)
            REG_MODULUS:   modulus_in   = wdata_wide[MOD_BITS-1:0];
            REG_ROW_POINT: row_point_in = csr_wdata;
            REG_COL_POINT: col_point_in = csr_wdata;
            REG_RATIO:     ratio_in     = csr_wdata;
            REG_NUM_ROWS:  num_rows_in  = csr_wdata[DIM_W-1:0];
            REG_NUM_COLS:  num_cols_in  = csr_wdata[DIM_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         modulus_ff   <= MOD_BITS'(2);
         row_point_ff <= CSR_W'(1);
         col_point_ff <= '0;
         ratio_ff     <= CSR_W'(1);
         num_rows_ff  <= '0;
         num_cols_ff  <= '0;
      end else begin
         modulus_ff   <= modulus_in;
         row_point_ff <= row_point_in;
         col_point_ff <= col_point_in;
         ratio_ff     <= ratio_in;
         num_rows_ff  <= num_rows_in;
         num_cols_ff  <= num_cols_in;
      end
   end

   cge_front #(.W(MOD_BITS), .MAX_DIM(MAX_DIM)) u_front (
      .clock    (clock),
      .reset    (reset),
      .req_ch   (req_ch),
      .modulus  (modulus_ff),
      .num_rows (num_rows_ff),
      .num_cols (num_cols_ff),
      .q_item   (q_item),
      .q_valid  (q_valid),
      .q_pop    (q_pop)
   );

   cge_back #(.W(MOD_BITS)) u_back (
      .clock     (clock),
      .reset     (reset),
      .q_item    (q_item),
      .q_valid   (q_valid),
      .q_pop     (q_pop),
      .modulus   (modulus_ff),
      .row_point (row_point_ff),
      .col_point (col_point_ff),
      .ratio     (ratio_ff),
      .rsp_ch    (rsp_ch)
   );

   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid |-> (rsp_ch.status == ST_OK || rsp_ch.status == ST_RANGE ||
                        rsp_ch.status == ST_NOINV))
      else $error("result status code out of range");

   a_error_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_ch.valid && rsp_ch.status != ST_OK) |-> (rsp_ch.entry_value == '0))
      else $error("error result carries a nonzero entry");

   a_entry_reduced: assert property (@(posedge clock) disable iff (reset)
      (rsp_ch.valid && rsp_ch.status == ST_OK) |->
         (DVD_W'(rsp_ch.entry_value) < DVD_W'(modulus_ff)))
      else $error("entry not reduced below modulus");

endmodule

/* tb/tb_cauchy_geometric_entry_mod_p_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_cauchy_geometric_entry_mod_p_core
// Checks each Cauchy entry 1 / (u1*rho^i - v1*rho^j) mod p against a
// wide-arithmetic predictor, over directed corner cases and random phases.
// ----------------------------------------------------------------------------
module tb_cauchy_geometric_entry_mod_p_core;
   import cge_pkg::*;

   typedef struct {
      bit [62:0] value;
      bit [1:0]  status;
   } entry_type;

   logic clock;
   logic reset;
   logic                csr_we;
   logic [CSR_A_W-1:0]  csr_index;
   logic [CSR_W-1:0]    csr_wdata;

   cge_req_if req_if ();
   cge_rsp_if rsp_if ();

   cauchy_geometric_entry_mod_p_core dut (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_if),
      .rsp_ch    (rsp_if),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // shadow copy of the registers
   bit [62:0] cfg_modulus;
   bit [62:0] cfg_row_point;
   bit [62:0] cfg_col_point;
   bit [62:0] cfg_ratio;
   bit [12:0] cfg_rows;
   bit [12:0] cfg_cols;

   entry_type pending_entries[$];
   int     tx_idle;
   int     rx_idle;
   int     hold_left;
   int     mismatches;

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   initial begin
      #700_000_000;
      $display("end of test: mismatches");
      $finish;
   end

   function automatic bit [63:0] mod_mul(bit [63:0] a, bit [63:0] b, bit [63:0] p);
      bit [127:0] prod;
      prod = {64'b0, a} * {64'b0, b};
      return prod % {64'b0, p};
   endfunction

   function automatic bit [63:0] mod_pow(bit [63:0] base, bit [11:0] e, bit [63:0] p);
      bit [63:0] acc;
      acc = 64'd1 % p;
      while (e != 0) begin
         if (e[0]) acc = mod_mul(acc, base, p);
         base = mod_mul(base, base, p);
         e = e >> 1;
      end
      return acc;
   endfunction

   function automatic bit [63:0] mod_sub(bit [63:0] a, bit [63:0] b, bit [63:0] p);
      return (a >= b) ? a - b : a + (p - b);
   endfunction

   // extended Euclid; returns 0 when d has no inverse
   function automatic bit mod_inverse(bit [63:0] d, bit [63:0] p, output bit [63:0] inv);
      bit [63:0] r0, r1, t0, t1, q, nr, nt;
      r0 = p; r1 = d; t0 = 0; t1 = 1;
      while (r1 != 0) begin
         q  = r0 / r1;
         nr = r0 - q * r1;
         nt = mod_sub(t0, mod_mul(q % p, t1, p), p);
         r0 = r1; r1 = nr; t0 = t1; t1 = nt;
      end
      inv = t0;
      return r0 == 1;
   endfunction

   function automatic entry_type predict_entry(bit [11:0] row, bit [11:0] col);
      entry_type res;
      bit [63:0] p, u, v, rho, a, b, inv;
      int        rows, cols;
      rows = (cfg_rows > 4096) ? 4096 : cfg_rows;
      cols = (cfg_cols > 4096) ? 4096 : cfg_cols;
      p = cfg_modulus;
      res.value = 0;
      if (row >= rows || col >= cols) begin
         res.status = ST_RANGE;
         return res;
      end
      if (p < 2) begin
         res.status = ST_NOINV;
         return res;
      end
      u   = cfg_row_point % p;
      v   = cfg_col_point % p;
      rho = cfg_ratio % p;
      a = mod_mul(u, mod_pow(rho, row, p), p);
      b = mod_mul(v, mod_pow(rho, col, p), p);
      if (!mod_inverse(mod_sub(a, b, p), p, inv)) begin
         res.status = ST_NOINV;
         return res;
      end
      res.value  = inv[62:0];
      res.status = ST_OK;
      return res;
   endfunction

   // result checker and receiver stall control
   always @(posedge clock) begin
      entry_type want;
      if (reset) begin
         rsp_if.ready <= 1'b0;
      end else begin
         if (rsp_if.valid && rsp_if.ready) begin
            if (pending_entries.size() == 0) begin
               $error("unexpected result: entry_value %0d status %0d",
                      rsp_if.entry_value, rsp_if.status);
               mismatches++;
            end else begin
               want = pending_entries.pop_front();
               if (rsp_if.entry_value !== want.value) begin
                  $error("entry_value: expected %0d, actual %0d",
                         want.value, rsp_if.entry_value);
                  mismatches++;
               end
               if (rsp_if.status !== want.status) begin
                  $error("status: expected %0d, actual %0d", want.status, rsp_if.status);
                  mismatches++;
               end
            end
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_if.ready <= 1'b0;
         end else begin
            rsp_if.ready <= ($urandom_range(99) >= rx_idle);
         end
      end
   end

   task automatic write_reg(logic [CSR_A_W-1:0] idx, bit [62:0] data);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      csr_we <= 1'b0;
      case (idx)
         REG_MODULUS:   cfg_modulus   = data;
         REG_ROW_POINT: cfg_row_point = data;
         REG_COL_POINT: cfg_col_point = data;
         REG_RATIO:     cfg_ratio     = data;
         REG_NUM_ROWS:  cfg_rows      = data[12:0];
         REG_NUM_COLS:  cfg_cols      = data[12:0];
         default: ;
      endcase
   endtask

   task automatic setup_matrix(bit [62:0] p, bit [62:0] u, bit [62:0] v, bit [62:0] rho,
                               bit [62:0] rows, bit [62:0] cols);
      write_reg(REG_MODULUS, p);
      write_reg(REG_ROW_POINT, u);
      write_reg(REG_COL_POINT, v);
      write_reg(REG_RATIO, rho);
      write_reg(REG_NUM_ROWS, rows);
      write_reg(REG_NUM_COLS, cols);
   endtask

   // valid stays high from one transaction to the next unless a gap is drawn
   task automatic send_entry(bit [11:0] row, bit [11:0] col);
      while ($urandom_range(99) < tx_idle) begin
         req_if.valid <= 1'b0;
         @(posedge clock);
      end
      req_if.valid     <= 1'b1;
      req_if.row_index <= row;
      req_if.col_index <= col;
      do @(posedge clock); while (!req_if.ready);
      pending_entries.push_back(predict_entry(row, col));
   endtask

   task automatic drain_entries();
      req_if.valid <= 1'b0;
      while (pending_entries.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   task automatic test_reset_config();
      send_entry(0, 0);
      send_entry(12'hFFF, 12'hFFF);
      drain_entries();
   endtask

   task automatic test_directed();
      // 101 prime, ratio 3
      setup_matrix(101, 5, 7, 3, 16, 16);
      send_entry(0, 0);
      send_entry(3, 9);
      send_entry(15, 15);
      send_entry(16, 0);
      send_entry(0, 16);
      send_entry(12'hFFF, 0);
      drain_entries();
      // u1 == v1 makes the diagonal zero; row point and ratio above modulus
      setup_matrix(101, 5 + 101 * 1000, 5, 3 + 202, 8, 8);
      send_entry(2, 2);
      send_entry(0, 0);
      send_entry(1, 4);
      drain_entries();
      // composite modulus, denominators sharing a factor
      setup_matrix(60, 6, 2, 7, 6, 6);
      send_entry(0, 0);
      send_entry(1, 2);
      send_entry(3, 5);
      drain_entries();
      // modulus zero and one
      setup_matrix(0, 3, 1, 2, 4, 4);
      send_entry(1, 1);
      send_entry(5, 1);
      drain_entries();
      write_reg(REG_MODULUS, 1);
      send_entry(0, 3);
      drain_entries();
      // widest modulus, dimension saturation, full-width indices
      setup_matrix(63'h7FFF_FFFF_FFFF_FFFF, 63'h7FFF_FFFF_FFFF_FFFE, 0,
                   63'h7FFF_FFFF_FFFF_FFFE, 13'h1FFF, 4096);
      send_entry(12'hFFF, 12'hFFF);
      send_entry(12'hAAA, 12'h555);
      drain_entries();
      // upper data bits above a dimension field are dropped
      setup_matrix(63'h7FFF_FFFF_FFFF_FFE7, 1, 63'h7FFF_FFFF_FFFF_FFE6, 2,
                   63'h4000_0000_0000_2005, 63'h2003);
      send_entry(4, 2);
      send_entry(5, 0);
      send_entry(0, 3);
      drain_entries();
   endtask

   task automatic test_pressure();
      setup_matrix(257, 3, 11, 5, 8, 8);
      hold_left = 3000;
      repeat (10) send_entry($urandom_range(0, 9), $urandom_range(0, 9));
      // hold the sender until everything has come back
      req_if.valid <= 1'b0;
      while (pending_entries.size() != 0) @(posedge clock);
      repeat (6) send_entry($urandom_range(0, 9), $urandom_range(0, 9));
      drain_entries();
   endtask

   task automatic random_phase();
      bit [62:0] p;
      int        rows, cols, count, pick;
      bit        wide;
      pick = $urandom_range(99);
      wide = 0;
      if (pick < 60) begin
         p = $urandom_range(2, 65535);
      end else if (pick < 75) begin
         p = {$urandom, $urandom};
         wide = 1;
      end else if (pick < 85) begin
         p = $urandom_range(0, 2);
      end else begin
         p = {$urandom_range(1, 255), 32'h0} | $urandom;
      end
      rows = ($urandom_range(9) == 0) ? (4090 + $urandom_range(0, 4000)) : $urandom_range(0, 24);
      cols = ($urandom_range(9) == 0) ? (4090 + $urandom_range(0, 4000)) : $urandom_range(0, 24);
      setup_matrix(p, {$urandom, $urandom}, {$urandom, $urandom},
                   ($urandom_range(3) == 0) ? {$urandom, $urandom} : $urandom_range(0, 40),
                   rows, cols);
      count = wide ? 15 : 45;
      repeat (count) begin
         if ($urandom_range(9) == 0)
            send_entry($urandom_range(0, 4095), $urandom_range(0, 4095));
         else
            send_entry($urandom_range(0, (rows > 30 ? 30 : rows) + 2),
                       $urandom_range(0, (cols > 30 ? 30 : cols) + 2));
      end
      drain_entries();
   endtask

   task automatic test_random();
      tx_idle = 11; rx_idle = 80;
      repeat (5) random_phase();
      tx_idle = 80; rx_idle = 11;
      repeat (5) random_phase();
      tx_idle = 0; rx_idle = 0;
      repeat (5) random_phase();
   endtask

   initial begin
      reset            = 1'b1;
      csr_we           = 1'b0;
      csr_index        = '0;
      csr_wdata        = '0;
      req_if.valid     = 1'b0;
      req_if.row_index = '0;
      req_if.col_index = '0;
      rsp_if.ready     = 1'b0;
      tx_idle    = 11;
      rx_idle    = 80;
      hold_left  = 0;
      mismatches = 0;
      cfg_modulus = 2; cfg_row_point = 1; cfg_col_point = 0;
      cfg_ratio = 1; cfg_rows = 0; cfg_cols = 0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_reset_config();
      test_directed();
      test_pressure();
      test_random();
      if (mismatches == 0)
         $display("end of test: clean");
      else
         $display("end of test: mismatches");
      $finish;
   end

endmodule

/* filelist.f */
sv/cge_pkg.sv
sv/cge_ifc.sv
sv/cge_front.sv
sv/cge_div.sv
sv/cge_mulmod.sv
sv/cge_back.sv
sv/cauchy_geometric_entry_mod_p_core.sv
tb/tb_cauchy_geometric_entry_mod_p_core.sv
